// ----- rtl/ptrag_pkg.sv -----
// shared types, constants and codes for the permute tile read address generator
// no dependencies
package ptrag_pkg;

    localparam int DEF_MAX_BLOCK = 8;
    localparam int DEF_MAX_AXES  = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int WORD_W  = 32;
    localparam int EXT_W   = 16;
    localparam int AXIS_W  = 48;
    localparam int SLOT_W  = 3;
    localparam int BS_W    = 4;
    localparam int ACNT_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int DCNT_W  = $clog2(WORD_W + 1);

    // register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PLANE_TILES = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_AXIS_COUNT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_AXIS_0      = 3'd3;

    // func codes of an input transaction
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BLOCK = 1'b1;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] start_index;
        logic [WORD_W-1:0] tile_count;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] in_page;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              done_res;
    } out_item_t;

    typedef enum logic {
        CMD_START,
        CMD_BLOCK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [WORD_W-1:0] start_index;
        logic [WORD_W-1:0] tile_count;
    } cmd_t;

    typedef struct packed {
        logic [BS_W-1:0]   block_size;
        logic [WORD_W-1:0] plane_tiles;
        logic [ACNT_W-1:0] axis_count;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLANE,
        ST_AXIS,
        ST_ACC,
        ST_EMIT,
        ST_DONE
    } back_state_t;

endpackage

// ----- rtl/ptrag_front.sv -----
// front end: accepts input transactions, classifies them and queues commands
// depends on ptrag_pkg
module ptrag_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ptrag_pkg::in_item_t in_item,
    output logic               q_valid,
    output ptrag_pkg::cmd_t    q_cmd,
    input  logic               q_pop
);
    import ptrag_pkg::*;

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    assign in_stall = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = queue_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.kind        = (in_item.func == FUNC_START) ? CMD_START : CMD_BLOCK;
        new_cmd.start_index = in_item.start_index;
        new_cmd.tile_count  = in_item.tile_count;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- rtl/ptrag_div.sv -----
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on ptrag_pkg
module ptrag_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptrag_pkg::div_req_t  req,
    output ptrag_pkg::div_resp_t resp
);
    import ptrag_pkg::*;

    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              qbit;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = !diff[WORD_W];

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = DCNT_W'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], qbit};
            rem_next = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = dvd_reg;
    assign resp.remainder = rem_reg;

endmodule

// ----- rtl/ptrag_back.sv -----
// back end: job state, base page computation and read command emission
// depends on ptrag_pkg; drives the shared divider ptrag_div
module ptrag_back #(
    parameter int MAX_BLOCK = ptrag_pkg::DEF_MAX_BLOCK,
    parameter int MAX_AXES  = ptrag_pkg::DEF_MAX_AXES
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  ptrag_pkg::cmd_t                         q_cmd,
    output logic                                    q_pop,
    input  ptrag_pkg::cfg_t                         cfg,
    input  logic [MAX_AXES-1:0][ptrag_pkg::AXIS_W-1:0] axis,
    output ptrag_pkg::div_req_t                     div_req,
    input  ptrag_pkg::div_resp_t                    div_resp,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output ptrag_pkg::out_item_t                    out_item
);
    import ptrag_pkg::*;

    localparam int EFF_BLOCK = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
    localparam int RUN_W     = $clog2(EFF_BLOCK + 1);
    localparam int AX_W      = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

    back_state_t       state_reg, state_next;
    logic [WORD_W-1:0] idx_reg, idx_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  emit_cnt_reg;
    logic [AX_W-1:0]   ax_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic [BS_W-1:0]   bs_eff;
    logic [WORD_W-1:0] plane_eff;
    logic [ACNT_W-1:0] n_eff;
    logic [AX_W-1:0]   ax_first;
    logic [AX_W-1:0]   ax_sel;
    logic [EXT_W-1:0]  ext_raw;
    logic [WORD_W-1:0] ext_eff;
    logic [WORD_W-1:0] plane_room;
    logic [WORD_W-1:0] run_wide;
    logic [WORD_W+EXT_W-1:0] prod_full;
    logic              out_free;
    logic              emit_last;

    // control decoded by the output block
    logic              pop_cmd;
    logic              load_job;
    logic              start_plane_div;
    logic              start_axis_div;
    logic              next_axis_div;
    logic              take_plane;
    logic              take_axis;
    logic              acc_step;
    logic              emit_fire;
    logic              done_fire;

    always_comb
    begin
        bs_eff = (cfg.block_size == '0) ? BS_W'(1) : cfg.block_size;
        if (bs_eff > BS_W'(EFF_BLOCK))
        begin
            bs_eff = BS_W'(EFF_BLOCK);
        end
        plane_eff = (cfg.plane_tiles == '0) ? WORD_W'(1) : cfg.plane_tiles;
        n_eff = (cfg.axis_count == '0) ? ACNT_W'(1) : cfg.axis_count;
        if (n_eff > ACNT_W'(MAX_AXES))
        begin
            n_eff = ACNT_W'(MAX_AXES);
        end
    end

    assign ax_first = AX_W'(n_eff - 1'b1);
    // axis whose extent feeds the divider when it starts this cycle
    assign ax_sel   = (state_reg == ST_PLANE) ? ax_first : ax_reg - 1'b1;
    assign ext_raw  = axis[ax_sel][AXIS_W-1:WORD_W];
    assign ext_eff  = (ext_raw == '0) ? WORD_W'(1) : WORD_W'(ext_raw);

    always_comb
    begin
        plane_room = plane_eff - div_resp.remainder;
        run_wide   = WORD_W'(bs_eff);
        if (plane_room < run_wide)
        begin
            run_wide = plane_room;
        end
        if (left_reg < run_wide)
        begin
            run_wide = left_reg;
        end
    end

    assign prod_full = div_resp.remainder[EXT_W-1:0] * axis[ax_reg][WORD_W-1:0];
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = (emit_cnt_reg + RUN_W'(1)) == run_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.kind == CMD_BLOCK)
                begin
                    state_next = (left_reg == '0) ? ST_DONE : ST_PLANE;
                end
            end
            ST_PLANE:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = (ax_reg == '0) ? ST_EMIT : ST_AXIS;
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop_cmd         = 1'b0;
        load_job        = 1'b0;
        start_plane_div = 1'b0;
        start_axis_div  = 1'b0;
        next_axis_div   = 1'b0;
        take_plane      = 1'b0;
        take_axis       = 1'b0;
        acc_step        = 1'b0;
        emit_fire       = 1'b0;
        done_fire       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop_cmd         = q_valid;
                load_job        = q_valid && q_cmd.kind == CMD_START;
                start_plane_div = q_valid && q_cmd.kind == CMD_BLOCK && left_reg != '0;
            end
            ST_PLANE:
            begin
                take_plane     = div_resp.done;
                start_axis_div = div_resp.done;
            end
            ST_AXIS:
            begin
                take_axis = div_resp.done;
            end
            ST_ACC:
            begin
                acc_step      = 1'b1;
                next_axis_div = (ax_reg != '0);
            end
            ST_EMIT:
            begin
                emit_fire = out_free;
            end
            ST_DONE:
            begin
                done_fire = out_free;
            end
            default:
            begin
                pop_cmd = 1'b0;
            end
        endcase
    end

    assign q_pop = pop_cmd;

    always_comb
    begin
        div_req.start    = start_plane_div || start_axis_div || next_axis_div;
        div_req.dividend = idx_reg;
        div_req.divisor  = plane_eff;
        if (start_axis_div)
        begin
            div_req.divisor = ext_eff;
        end
        else if (next_axis_div)
        begin
            div_req.dividend = quo_reg;
            div_req.divisor  = ext_eff;
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        left_next = left_reg;
        if (load_job)
        begin
            idx_next  = q_cmd.start_index;
            left_next = q_cmd.tile_count;
        end
        else if (emit_fire && emit_last)
        begin
            idx_next  = idx_reg + WORD_W'(run_reg);
            left_next = left_reg - WORD_W'(run_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            if (emit_fire || done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_plane)
        begin
            run_reg      <= RUN_W'(run_wide);
            ax_reg       <= ax_first;
            acc_reg      <= '0;
            emit_cnt_reg <= '0;
        end
        if (take_axis)
        begin
            quo_reg  <= div_resp.quotient;
            prod_reg <= prod_full[WORD_W-1:0];
        end
        if (acc_step)
        begin
            acc_reg <= acc_reg + prod_reg;
            if (ax_reg != '0)
            begin
                ax_reg <= ax_reg - 1'b1;
            end
        end
        if (emit_fire)
        begin
            out_item_reg.in_page  <= acc_reg + WORD_W'(emit_cnt_reg);
            out_item_reg.slot     <= SLOT_W'(emit_cnt_reg);
            out_item_reg.last     <= emit_last;
            out_item_reg.done_res <= 1'b0;
            emit_cnt_reg          <= emit_cnt_reg + RUN_W'(1);
        end
        else if (done_fire)
        begin
            out_item_reg.in_page  <= '0;
            out_item_reg.slot     <= '0;
            out_item_reg.last     <= 1'b0;
            out_item_reg.done_res <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/permute_tile_read_address_gen.sv -----
// Permute tile read address generator. A job start transaction (func 0) loads the
// first output tile index and the tile count into the back end. A block transaction
// (func 1) emits one read command per tile, up to block_size, stopping at a plane
// boundary or the end of the job; with nothing left it emits a single done result.
// The back end splits the output index with one shared radix-2 divider (32
// iterations): one division by the plane size and one per used axis, each axis
// adding an accumulate step, then one command per cycle while the output is not
// stalled. A queue of two transactions in front lets input be taken while a block
// is worked on.
// depends on ptrag_pkg, ptrag_front, ptrag_div, ptrag_back
module permute_tile_read_address_gen #(
    parameter int MAX_BLOCK = ptrag_pkg::DEF_MAX_BLOCK,
    parameter int MAX_AXES  = ptrag_pkg::DEF_MAX_AXES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ptrag_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ptrag_pkg::out_item_t          out_item,
    input  logic                          cfg_we,
    input  logic [ptrag_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [ptrag_pkg::AXIS_W-1:0]  cfg_data
);
    import ptrag_pkg::*;

    cfg_t                           cfg_reg;
    logic [MAX_AXES-1:0][AXIS_W-1:0] axis_reg;
    logic                           q_valid;
    cmd_t                           q_cmd;
    logic                           q_pop;
    div_req_t                       div_req;
    div_resp_t                      div_resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size  <= BS_W'(8);
            cfg_reg.plane_tiles <= WORD_W'(1);
            cfg_reg.axis_count  <= ACNT_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:  cfg_reg.block_size  <= cfg_data[BS_W-1:0];
                CFG_PLANE_TILES: cfg_reg.plane_tiles <= cfg_data[WORD_W-1:0];
                CFG_AXIS_COUNT:  cfg_reg.axis_count  <= cfg_data[ACNT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // extent 1, stride 0 after reset
    for (genvar k = 0; k < MAX_AXES; k++)
    begin : g_axis
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                axis_reg[k] <= {EXT_W'(1), WORD_W'(0)};
            end
            else if (cfg_we && cfg_index == CFG_AXIS_0 + CIDX_W'(k))
            begin
                axis_reg[k] <= cfg_data;
            end
        end
    end

    ptrag_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    ptrag_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    ptrag_back #(
        .MAX_BLOCK (MAX_BLOCK),
        .MAX_AXES  (MAX_AXES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .axis      (axis_reg),
        .div_req   (div_req),
        .div_resp  (div_resp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
